// ----- hdl/tobt_pkg.sv -----
package tobt_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_ARM   = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  // fixed field widths
  localparam int ACT_W = 2;
  localparam int ID_W  = 4;

  // at most this many expiries are reported by one check
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

endpackage

// ----- hdl/tobt_in_if.sv -----
interface tobt_in_if import tobt_pkg::*; #(
  parameter int TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [ID_W-1:0]      timer_id;
  logic [TIME_BITS-1:0] period;
  logic                 repeat_req;
  logic [TIME_BITS-1:0] now;

  modport source (
    output valid, action, timer_id, period, repeat_req, now,
    input  ready
  );
  modport sink (
    input  valid, action, timer_id, period, repeat_req, now,
    output ready
  );
endinterface

// ----- hdl/tobt_out_if.sv -----
interface tobt_out_if import tobt_pkg::*;;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] expired_timer;
  logic            last;

  modport source (
    output valid, expired_timer, last,
    input  ready
  );
  modport sink (
    input  valid, expired_timer, last,
    output ready
  );
endinterface

// ----- hdl/oneshot_periodic_timer_bank_core.sv -----
// Arm and stop write on acceptance and leave the input ready; a new word is accepted the cycle after.
// A check scans the deadline/period memories one entry per cycle while the output
// side does not stall; back-pressure holds the scan.
// An expiry word waits in a holding slot until the next expiry or the scan end, and
// only then moves into the output register.
// rst_ni (async, active low) clears the marks and the control, not the memories.
module oneshot_periodic_timer_bank_core import tobt_pkg::*; #(
  parameter int TIMERS    = 16,
  parameter int TIME_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tobt_in_if.sink    in_i,
  tobt_out_if.source out_o
);

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  state_e                 state_q;
  logic [IDX_W:0]         rd_cnt_q;
  logic                   s1_valid_q;
  logic [IDX_W-1:0]       s1_idx_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   pend_valid_q;
  logic [ID_W-1:0]        pend_id_q;
  logic                   out_valid_q;
  logic [ID_W-1:0]        out_id_q;
  logic                   out_last_q;
  logic [TIMERS-1:0]      active_q;
  logic [TIMERS-1:0]      periodic_q;

  // timer state memories, one read port with registered data
  logic [TIME_BITS-1:0]   deadline_mem [TIMERS];
  logic [TIME_BITS-1:0]   period_mem   [TIMERS];
  logic [TIME_BITS-1:0]   dl_rd_q;
  logic [TIME_BITS-1:0]   rp_rd_q;

  logic                   in_acc;
  logic                   id_ok;
  logic [IDX_W-1:0]       arm_idx;
  logic                   arm_en;
  logic                   stop_en;
  logic                   adv;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   hit;
  logic                   emit;
  logic                   scan_done;
  logic                   reload;
  logic                   out_load;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [TIME_BITS-1:0]   wr_dl_d;

  // input side
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign id_ok      = (32'(in_i.timer_id) < TIMERS);
  assign arm_idx    = IDX_W'(in_i.timer_id);
  assign arm_en     = in_acc && (in_i.action == ACT_ARM) && id_ok;
  assign stop_en    = in_acc && (in_i.action == ACT_STOP) && id_ok;

  // scan: read entry n while judging entry n-1; stall when output is blocked
  assign adv       = !out_valid_q || out_o.ready;
  assign rd_en     = (state_q == ST_SCAN) && adv && (rd_cnt_q != (IDX_W+1)'(TIMERS));
  assign rd_addr   = rd_cnt_q[IDX_W-1:0];
  assign hit       = (state_q == ST_SCAN) && adv && s1_valid_q && active_q[s1_idx_q] &&
                     (now_q >= dl_rd_q);
  assign emit      = hit && (cnt_q < CNT_W'(MAX_RESULTS));
  assign reload    = hit && periodic_q[s1_idx_q];
  assign scan_done = (state_q == ST_SCAN) && adv && !s1_valid_q &&
                     (rd_cnt_q == (IDX_W+1)'(TIMERS));

  // one-deep holding slot lets the final word carry last
  assign out_load = pend_valid_q && (emit || scan_done);

  // deadline write port: arm or periodic reload
  assign wr_en   = arm_en || reload;
  assign wr_addr = arm_en ? arm_idx : s1_idx_q;
  assign wr_dl_d = arm_en ? (in_i.now + in_i.period) : (now_q + rp_rd_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      deadline_mem[wr_addr] <= wr_dl_d;
    end
    if (arm_en) begin
      period_mem[arm_idx] <= in_i.period;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      dl_rd_q <= deadline_mem[rd_addr];
      rp_rd_q <= period_mem[rd_addr];
    end
  end

  // control, marks and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_cnt_q     <= '0;
      s1_valid_q   <= 1'b0;
      s1_idx_q     <= '0;
      now_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_id_q    <= '0;
      out_valid_q  <= 1'b0;
      out_id_q     <= '0;
      out_last_q   <= 1'b0;
      active_q     <= '0;
      periodic_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_id_q    <= pend_id_q;
        out_last_q  <= scan_done;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_i.action == ACT_CHECK)) begin
            state_q      <= ST_SCAN;
            rd_cnt_q     <= '0;
            s1_valid_q   <= 1'b0;
            cnt_q        <= '0;
            now_q        <= in_i.now;
            pend_valid_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (adv) begin
            s1_valid_q <= rd_en;
            if (rd_en) begin
              s1_idx_q <= rd_addr;
              rd_cnt_q <= rd_cnt_q + (IDX_W+1)'(1);
            end
            if (emit) begin
              pend_valid_q <= 1'b1;
              pend_id_q    <= ID_W'(s1_idx_q);
              cnt_q        <= cnt_q + CNT_W'(1);
            end
            if (scan_done) begin
              pend_valid_q <= 1'b0;
              state_q      <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (arm_en) begin
        active_q[arm_idx]   <= 1'b1;
        periodic_q[arm_idx] <= in_i.repeat_req;
      end
      if (stop_en) begin
        active_q[arm_idx] <= 1'b0;
      end
      if (hit && !periodic_q[s1_idx_q]) begin
        active_q[s1_idx_q] <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.expired_timer = out_id_q;
  assign out_o.last          = out_last_q;

  // a check always starts a scan
  a_check_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.action == ACT_CHECK)) |=> (state_q == ST_SCAN))
    else $error("check did not start a scan");

  // reported count never exceeds the limit
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("result count overflow");

  // reload write-back never hits the entry being read
  a_no_rmw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reload && rd_en) |-> (wr_addr != rd_addr))
    else $error("write-back collides with read");

  // the final word of a check leaves the holding slot empty
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |=> (!pend_valid_q && (state_q == ST_IDLE)))
    else $error("holding slot not drained at end of check");

endmodule
